@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top RTL file of the sine tone generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define DCSTG_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Whenever the antecedent is true, the consequent must hold in the same cycle.
`define DCSTG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define DCSTG_ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define DCSTG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ hw/rtl/dcstg_pkg.sv @@
// Shared types and constants of the sine tone generator.
package dcstg_pkg;

   // Fixed field widths.
   localparam int ACC_W     = 18;
   localparam int BUF_W     = 13;
   localparam int SAMPLE_W  = 16;
   localparam int CSR_IDX_W = 2;

   // Shared divider and multiplier widths.
   localparam int DIV_W     = 32;
   localparam int DIV_CNT_W = 6;
   localparam int MUL_W     = 32;

   // Taylor series: number of correction terms and counter width.
   localparam int TERMS = 9;
   localparam int K_W   = 4;
   localparam int SUM_W = 34;

   // Fixed-point constants in Q2.30, and the sample full scale.
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [15:0] FULL_SCALE  = 16'h7FFF;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FREQUENCY      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_SAMPLES = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [ACC_W-1:0] FREQUENCY_RST      = 18'd1000;
   localparam logic [ACC_W-1:0] SAMPLE_RATE_RST    = 18'd48000;
   localparam logic [BUF_W-1:0] BUFFER_SAMPLES_RST = 13'd4096;

   // Request to the shared divider.
   typedef struct packed {
      logic                 start;
      logic [ACC_W-1:0]     init_rem;
      logic [DIV_W-1:0]     numer;
      logic [ACC_W-1:0]     divisor;
      logic [DIV_CNT_W-1:0] steps;
   } div_req_type;

   // Status and results of the shared divider.
   typedef struct packed {
      logic             busy;
      logic [DIV_W-1:0] quot;
      logic [ACC_W-1:0] rem;
   } div_rsp_type;

   // Division by (2k)(2k+1) as a multiply: shift out the power of two, multiply by
   // the rounded-up reciprocal of the odd part, then drop the fraction bits.
   typedef struct packed {
      logic [2:0]       pre_shift;
      logic [5:0]       post_shift;
      logic [MUL_W-1:0] factor;
   } recip_type;

   // Exact for every dividend below 2^32, since the shifted dividend has 31 bits.
   function automatic recip_type taylor_recip(input logic [K_W-1:0] k);
      recip_type r;
      unique case (k)
         4'd1:    r = '{3'd1, 6'd33, MUL_W'((64'd1 << 33) / 64'd3 + 64'd1)};
         4'd2:    r = '{3'd2, 6'd34, MUL_W'((64'd1 << 34) / 64'd5 + 64'd1)};
         4'd3:    r = '{3'd1, 6'd36, MUL_W'((64'd1 << 36) / 64'd21 + 64'd1)};
         4'd4:    r = '{3'd3, 6'd35, MUL_W'((64'd1 << 35) / 64'd9 + 64'd1)};
         4'd5:    r = '{3'd1, 6'd37, MUL_W'((64'd1 << 37) / 64'd55 + 64'd1)};
         4'd6:    r = '{3'd2, 6'd37, MUL_W'((64'd1 << 37) / 64'd39 + 64'd1)};
         4'd7:    r = '{3'd1, 6'd38, MUL_W'((64'd1 << 38) / 64'd105 + 64'd1)};
         4'd8:    r = '{3'd4, 6'd36, MUL_W'((64'd1 << 36) / 64'd17 + 64'd1)};
         4'd9:    r = '{3'd1, 6'd39, MUL_W'((64'd1 << 39) / 64'd171 + 64'd1)};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/dual_channel_sine_tone_generator.sv @@
// Per item: reduce the stored phase modulo the rate, divide out the phase fraction, run the
// Taylor series (skipped when the phase falls on a multiple of a quarter wave), then reduce
// the frequency modulo the rate. A new item is taken only once the last one has left ST_DONE;
// the shared restoring divider (one bit per cycle) serves both modulo steps and the phase fraction.
// A finished item waits in the output register; a later item waits in ST_DONE until that one is taken.
// Reset (synchronous, active high) restores the register defaults and zeroes phase and index.
module dual_channel_sine_tone_generator import dcstg_pkg::*; #(
   parameter int MAX_BUFFER_FRAMES = 4096,
   parameter int PHASE_BITS        = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input items
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_restart,
   // Result items
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [15:0]    rsp_left_sample,
   output logic signed [15:0]    rsp_right_sample,
   output logic                  rsp_last_of_buffer,
   // Configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ACC_W-1:0]      csr_data
);

`include "assert_macros.svh"

   localparam int IDX_W = (MAX_BUFFER_FRAMES > 1) ? $clog2(MAX_BUFFER_FRAMES) : 1;
   localparam int N_W   = $clog2(MAX_BUFFER_FRAMES + 1);
   localparam int A_W   = PHASE_BITS - 1;
   localparam int REM_W = PHASE_BITS - 2;
   localparam logic [A_W-1:0] QUARTER = {1'b1, {REM_W{1'b0}}};

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_ACCMOD = 12'b0000_0000_0010,
      ST_PHASE  = 12'b0000_0000_0100,
      ST_XSQ    = 12'b0000_0000_1000,
      ST_X2     = 12'b0000_0001_0000,
      ST_TDIV   = 12'b0000_0010_0000,
      ST_TWAIT  = 12'b0000_0100_0000,
      ST_CLAMP  = 12'b0000_1000_0000,
      ST_MAG    = 12'b0001_0000_0000,
      ST_FREQ   = 12'b0010_0000_0000,
      ST_FWAIT  = 12'b0100_0000_0000,
      ST_DONE   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [ACC_W-1:0] freq_ff;
   logic [ACC_W-1:0] rate_ff;
   logic [BUF_W-1:0] bufs_ff;

   // Tone state and per-item working registers.
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [ACC_W-1:0]      acc_mod_ff, acc_mod_in;
   logic [1:0]            quad_ff, quad_in;
   logic [MUL_W-1:0]      x_ff, x_in;
   logic [MUL_W-1:0]      x2_ff, x2_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [K_W-1:0]        k_ff, k_in;
   logic [SAMPLE_W-1:0]   mag_ff, mag_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic                  last_ff, last_in;

   // Shared units.
   div_req_type           div_req;
   div_rsp_type           div_rsp;
   logic [MUL_W-1:0]      mul_a, mul_b;
   logic [2*MUL_W-1:0]    prod;

   // Derived values.
   logic [ACC_W-1:0]      rate_eff;
   logic [N_W-1:0]        n_eff;
   logic [N_W-1:0]        idx_ext;
   logic [N_W-1:0]        idx_next_ext;
   logic                  new_buffer;
   logic [ACC_W-1:0]      acc_cur;
   logic [PHASE_BITS-1:0] phase;
   logic [1:0]            phase_quad;
   logic [A_W-1:0]        quarter_idx;
   logic [MUL_W-1:0]      x_val;
   logic [MUL_W-1:0]      prod_q30;
   recip_type             recip;
   logic [MUL_W-1:0]      term_q;
   logic signed [SUM_W-1:0] term_s;
   logic [30:0]           sum_clamped;
   logic [ACC_W:0]        acc_sum;
   logic [ACC_W:0]        acc_wrap;
   logic                  out_free;

   dcstg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dcstg_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // Effective rate and buffer length after the out-of-range rules.
   assign rate_eff = (rate_ff == '0) ? ACC_W'(1) : rate_ff;

   always_comb begin
      if (bufs_ff == '0) begin
         n_eff = N_W'(1);
      end else if (32'(bufs_ff) > 32'(MAX_BUFFER_FRAMES)) begin
         n_eff = N_W'(MAX_BUFFER_FRAMES);
      end else begin
         n_eff = N_W'(bufs_ff);
      end
   end

   // Frame index tests, and the phase that the item starts from.
   assign idx_ext      = N_W'(idx_ff);
   assign idx_next_ext = idx_ext + N_W'(1);
   assign new_buffer   = req_restart || (idx_ext >= n_eff);
   assign acc_cur      = new_buffer ? '0 : acc_ff;

   // Phase word split into quadrant and mirrored quarter-wave index.
   assign phase       = div_rsp.quot[PHASE_BITS-1:0];
   assign phase_quad  = phase[PHASE_BITS-1:PHASE_BITS-2];
   assign quarter_idx = phase_quad[0] ? (QUARTER - {1'b0, phase[REM_W-1:0]})
                                      : {1'b0, phase[REM_W-1:0]};

   // Product taps for the Q2.30 datapath.
   assign x_val    = prod[REM_W +: MUL_W];
   assign prod_q30 = prod[30 +: MUL_W];

   // Taylor term quotient taken from the reciprocal product.
   assign recip  = taylor_recip(k_ff);
   assign term_q = MUL_W'(prod >> recip.post_shift);
   assign term_s = $signed({2'b00, term_q});

   // Clamp the series sum to the range zero to one.
   always_comb begin
      if (sum_ff[SUM_W-1]) begin
         sum_clamped = '0;
      end else if (sum_ff > $signed(SUM_W'(ONE_Q30))) begin
         sum_clamped = ONE_Q30;
      end else begin
         sum_clamped = sum_ff[30:0];
      end
   end

   // Next accumulator: add the reduced frequency and wrap once at the rate.
   assign acc_sum  = {1'b0, acc_mod_ff} + {1'b0, div_rsp.rem};
   assign acc_wrap = (acc_sum >= {1'b0, rate_eff}) ? (acc_sum - {1'b0, rate_eff}) : acc_sum;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: drives the shared divider and multiplier step by step.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      acc_mod_in   = acc_mod_ff;
      quad_in      = quad_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      sum_in       = sum_ff;
      k_in         = k_ff;
      mag_in       = mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sample_in    = sample_ff;
      last_in      = last_ff;
      div_req      = '0;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (new_buffer) begin
                  idx_in = '0;
                  acc_in = '0;
               end
               // Reduce a stale accumulator modulo the rate.
               div_req.start    = 1'b1;
               div_req.init_rem = '0;
               div_req.numer    = {acc_cur, {(DIV_W-ACC_W){1'b0}}};
               div_req.divisor  = rate_eff;
               div_req.steps    = DIV_CNT_W'(ACC_W);
               state_in         = ST_ACCMOD;
            end
         end
         ST_ACCMOD: begin
            if (!div_rsp.busy) begin
               // Phase fraction acc * 2^PHASE_BITS / rate.
               acc_mod_in       = div_rsp.rem;
               div_req.start    = 1'b1;
               div_req.init_rem = div_rsp.rem;
               div_req.numer    = '0;
               div_req.divisor  = rate_eff;
               div_req.steps    = DIV_CNT_W'(PHASE_BITS);
               state_in         = ST_PHASE;
            end
         end
         ST_PHASE: begin
            if (!div_rsp.busy) begin
               quad_in = phase_quad;
               if (quarter_idx == '0) begin
                  mag_in   = '0;
                  state_in = ST_FREQ;
               end else if (quarter_idx == QUARTER) begin
                  mag_in   = FULL_SCALE;
                  state_in = ST_FREQ;
               end else begin
                  mul_a    = MUL_W'(HALF_PI_Q30);
                  mul_b    = MUL_W'(quarter_idx);
                  state_in = ST_XSQ;
               end
            end
         end
         ST_XSQ: begin
            // Angle x in Q2.30; start the series with x and square it.
            x_in     = x_val;
            sum_in   = $signed(SUM_W'(x_val));
            mul_a    = x_val;
            mul_b    = x_val;
            state_in = ST_XSQ == state_ff ? ST_X2 : ST_X2;
         end
         ST_X2: begin
            x2_in    = prod_q30;
            mul_a    = x_ff;
            mul_b    = prod_q30;
            k_in     = K_W'(1);
            state_in = ST_TDIV;
         end
         ST_TDIV: begin
            // Divide the term product by (2k)(2k+1) through its reciprocal.
            mul_a    = prod_q30 >> recip.pre_shift;
            mul_b    = recip.factor;
            state_in = ST_TWAIT;
         end
         ST_TWAIT: begin
            // Odd terms subtract, even terms add.
            sum_in = k_ff[0] ? (sum_ff - term_s) : (sum_ff + term_s);
            if (k_ff == K_W'(TERMS)) begin
               state_in = ST_CLAMP;
            end else begin
               k_in     = k_ff + K_W'(1);
               mul_a    = term_q;
               mul_b    = x2_ff;
               state_in = ST_TDIV;
            end
         end
         ST_CLAMP: begin
            mul_a    = MUL_W'(sum_clamped);
            mul_b    = MUL_W'(FULL_SCALE);
            state_in = ST_MAG;
         end
         ST_MAG: begin
            mag_in   = prod[30 +: SAMPLE_W];
            state_in = ST_FREQ;
         end
         ST_FREQ: begin
            // Phase step: frequency modulo the rate.
            div_req.start    = 1'b1;
            div_req.init_rem = '0;
            div_req.numer    = {freq_ff, {(DIV_W-ACC_W){1'b0}}};
            div_req.divisor  = rate_eff;
            div_req.steps    = DIV_CNT_W'(ACC_W);
            state_in         = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (!div_rsp.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               sample_in    = quad_ff[1] ? (~mag_ff + SAMPLE_W'(1)) : mag_ff;
               last_in      = (idx_ext == (n_eff - N_W'(1)));
               if (idx_next_ext >= n_eff) begin
                  idx_in = '0;
                  acc_in = '0;
               end else begin
                  idx_in = IDX_W'(idx_next_ext);
                  acc_in = acc_wrap[ACC_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         acc_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         freq_ff      <= FREQUENCY_RST;
         rate_ff      <= SAMPLE_RATE_RST;
         bufs_ff      <= BUFFER_SAMPLES_RST;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_FREQUENCY:      freq_ff <= csr_data;
               CSR_SAMPLE_RATE:    rate_ff <= csr_data;
               CSR_BUFFER_SAMPLES: bufs_ff <= csr_data[BUF_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_mod_ff <= acc_mod_in;
      quad_ff    <= quad_in;
      x_ff       <= x_in;
      x2_ff      <= x2_in;
      sum_ff     <= sum_in;
      mag_ff     <= mag_in;
      sample_ff  <= sample_in;
      last_ff    <= last_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_sample    = $signed(sample_ff);
   assign rsp_right_sample   = $signed(sample_ff);
   assign rsp_last_of_buffer = last_ff;

   // The divider is only started when it has finished the previous job.
   `DCSTG_ASSERT_IMPLY(a_div_start_idle, clock, reset, div_req.start, !div_rsp.busy, "divider restarted while busy")
   // The reduced accumulator stays below the rate for the phase step.
   `DCSTG_ASSERT_IMPLY(a_acc_below_rate, clock, reset, state_ff == ST_DONE, acc_mod_ff < rate_eff, "reduced accumulator not below rate")
   // Taylor term counter stays within the series.
   `DCSTG_ASSERT_IMPLY(a_term_range, clock, reset, state_ff == ST_TDIV || state_ff == ST_TWAIT, k_ff >= K_W'(1) && k_ff <= K_W'(TERMS), "Taylor term counter out of range")
   // A result never reaches negative full scale.
   `DCSTG_ASSERT_IMPLY(a_sample_range, clock, reset, rsp_valid, rsp_left_sample != 16'sh8000, "sample outside symmetric range")

endmodule

@@ hw/rtl/dcstg_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module dcstg_div import dcstg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [ACC_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     num_ff;
   logic [ACC_W-1:0]     den_ff;

   logic [ACC_W:0] trial;
   logic [ACC_W:0] diff;
   logic           fits;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   // Control: step counter and busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (div_req.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= div_req.steps;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath: remainder and quotient shift register.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= div_req.init_rem;
         num_ff <= div_req.numer;
         den_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
         num_ff <= {num_ff[DIV_W-2:0], fits};
      end
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.quot = num_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

@@ hw/rtl/dcstg_mul.sv @@
// Shared unsigned multiplier with a registered product.
module dcstg_mul import dcstg_pkg::*; (
   input  logic                 clock,
   input  logic [MUL_W-1:0]     mul_a,
   input  logic [MUL_W-1:0]     mul_b,
   output logic [2*MUL_W-1:0]   prod
);

   logic [2*MUL_W-1:0] prod_ff;

   // One product per cycle, available the cycle after the operands.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the dual-channel sine tone generator.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dcstg_pkg::*;

   localparam int          PHASE_BITS    = 16;
   localparam int          MAX_FRAMES    = 4096;
   localparam bit [63:0]   QUARTER       = 64'd1 << (PHASE_BITS - 2);
   localparam bit [63:0]   HALF_PI_FX    = 64'd1686629713;
   localparam bit [63:0]   UNIT_FX       = 64'd1 << 30;
   localparam bit [63:0]   PEAK          = 64'd32767;
   localparam int          RANDOM_ITEMS  = 2000;
   localparam int          IDLE_LIMIT    = 5000;
   localparam int          END_WAIT      = 500;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          REPORT_CAP    = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // One expected stereo frame.
   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               last;
      int                 seq;
   } tone_frame_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [15:0]   rsp_left_sample;
   logic signed [15:0]   rsp_right_sample;
   logic                 rsp_last_of_buffer;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ACC_W-1:0]     csr_data = '0;

   // Predictor state: register copies, phase and position in the buffer.
   int unsigned tone_freq      = 1000;
   int unsigned tone_rate      = 48000;
   int unsigned frames_per_buf = 4096;
   int unsigned tone_phase     = 0;
   int unsigned frame_pos      = 0;

   tone_frame_type frames_expected[$];
   int          frames_sent  = 0;
   int          mismatches   = 0;
   int          quiet_cycles = 0;
   int          stall_left   = 0;
   bit          idle_on      = 1'b1;

   dual_channel_sine_tone_generator #(
      .MAX_BUFFER_FRAMES(MAX_FRAMES),
      .PHASE_BITS(PHASE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_left_sample(rsp_left_sample),
      .rsp_right_sample(rsp_right_sample),
      .rsp_last_of_buffer(rsp_last_of_buffer),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6ns clock = ~clock;

   // Magnitude of a quarter-wave sine at index a, Taylor series in Q2.30.
   function automatic bit [15:0] quarter_magnitude(bit [63:0] a);
      bit [63:0]        x;
      bit [63:0]        x2;
      bit [63:0]        term;
      bit [63:0]        s;
      bit signed [63:0] sum;
      int               k;
      if (a == 0) return 16'd0;
      if (a >= QUARTER) return 16'(PEAK);
      x = (HALF_PI_FX * a) >> (PHASE_BITS - 2);
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (k = 1; k <= 9; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      s = (sum < 0) ? 64'd0 : 64'(sum);
      if (s > UNIT_FX) s = UNIT_FX;
      return 16'((s * PEAK) >> 30);
   endfunction

   // Signed sample for a phase below the rate: quadrant select and mirroring.
   function automatic bit [15:0] tone_sample(int unsigned phase, int unsigned rate);
      bit [63:0] p;
      bit [63:0] rem;
      bit [63:0] idx;
      bit [1:0]  quad;
      bit [15:0] mag;
      p = (64'(phase) << PHASE_BITS) / 64'(rate);
      quad = 2'(p >> (PHASE_BITS - 2));
      rem = p & (QUARTER - 1);
      idx = quad[0] ? QUARTER - rem : rem;
      mag = quarter_magnitude(idx);
      return quad[1] ? (~mag + 16'd1) : mag;
   endfunction

   // Advance the tone by one item and queue the frame it produces.
   function automatic void advance_tone(bit restart);
      int unsigned rate;
      int unsigned frames;
      int unsigned phase;
      tone_frame_type f;
      rate = (tone_rate == 0) ? 1 : tone_rate;
      frames = (frames_per_buf == 0) ? 1 : frames_per_buf;
      if (frames > MAX_FRAMES) frames = MAX_FRAMES;
      // A restart or a buffer that shrank below the position starts a new buffer.
      if (restart || frame_pos >= frames) begin
         frame_pos = 0;
         tone_phase = 0;
      end
      phase = tone_phase % rate;
      f.left = tone_sample(phase, rate);
      f.right = f.left;
      f.last = (frame_pos == frames - 1);
      f.seq = frames_sent;
      frames_expected.push_back(f);
      frames_sent++;
      if (frame_pos + 1 >= frames) begin
         frame_pos = 0;
         tone_phase = 0;
      end else begin
         frame_pos++;
         phase = phase + tone_freq % rate;
         if (phase >= rate) phase = phase - rate;
         tone_phase = phase;
      end
   endfunction

   // Register write as seen by the predictor; unmapped indexes are dropped.
   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [ACC_W-1:0] data);
      case (idx)
         CSR_FREQUENCY: begin
            tone_freq = data;
         end
         CSR_SAMPLE_RATE: begin
            tone_rate = data;
         end
         CSR_BUFFER_SAMPLES: begin
            frames_per_buf = data[BUF_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 400);
   endfunction

   task automatic report_mismatch(string what, int seq, logic signed [31:0] got,
                                  logic signed [31:0] want);
      if (mismatches < REPORT_CAP) begin
         $display("item %0d: %s is %0d, expected %0d", seq, what, got, want);
      end
      mismatches++;
   endtask

   // Send one item; valid stays high into the next item unless a gap follows.
   task automatic send_frame(bit restart);
      int gap;
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      advance_tone(restart);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected frame has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (frames_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, only once the block has gone idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [ACC_W-1:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_reg(idx, data);
   endtask

   // Check each accepted frame and apply random backpressure.
   always @(posedge clock) begin : check_frames
      tone_frame_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_expected.size() == 0) begin
            report_mismatch("result with no item outstanding", -1, rsp_left_sample, 0);
         end else begin
            want = frames_expected.pop_front();
            if (rsp_left_sample !== want.left)
               report_mismatch("left_sample", want.seq, rsp_left_sample, want.left);
            if (rsp_right_sample !== want.right)
               report_mismatch("right_sample", want.seq, rsp_right_sample, want.right);
            if (rsp_last_of_buffer !== want.last)
               report_mismatch("last_of_buffer", want.seq, {31'd0, rsp_last_of_buffer},
                               {31'd0, want.last});
         end
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         stall_left = ($urandom_range(0, 7) == 0) ? pick_gap() : 0;
         rsp_ready <= (stall_left == 0);
      end
   end

   // Watchdog: too many cycles without any handshake ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Reset register values, with one restart in the middle.
   task automatic test_defaults();
      send_frame(1'b0);
      send_frame(1'b0);
      send_frame(1'b1);
      send_frame(1'b0);
   endtask

   // Phase exactly on each quarter wave: zero, full scale, zero, negative full scale.
   task automatic test_quadrants();
      write_reg(CSR_SAMPLE_RATE, 18'd4);
      write_reg(CSR_FREQUENCY, 18'd1);
      write_reg(CSR_BUFFER_SAMPLES, 18'd5);
      send_frame(1'b1);
      repeat (4) send_frame(1'b0);
   endtask

   // Out-of-range settings and settings changed in the middle of a buffer.
   task automatic test_open_cases();
      // Zero sample rate acts as a rate of one.
      write_reg(CSR_SAMPLE_RATE, 18'd0);
      write_reg(CSR_FREQUENCY, 18'h3FFFF);
      send_frame(1'b0);
      send_frame(1'b0);
      // Frequency far above the rate is reduced modulo the rate.
      write_reg(CSR_SAMPLE_RATE, 18'd7);
      write_reg(CSR_FREQUENCY, 18'h3FFFE);
      send_frame(1'b0);
      send_frame(1'b0);
      // A buffer size of zero behaves as one frame per buffer.
      write_reg(CSR_BUFFER_SAMPLES, 18'd0);
      send_frame(1'b0);
      send_frame(1'b0);
      // Oversized buffer saturates; highest rate with a near-full step.
      write_reg(CSR_BUFFER_SAMPLES, 18'h3FFFF);
      write_reg(CSR_SAMPLE_RATE, 18'd192000);
      write_reg(CSR_FREQUENCY, 18'd191999);
      send_frame(1'b1);
      send_frame(1'b0);
      // Rate lowered mid-buffer leaves a stale phase that must be reduced.
      write_reg(CSR_SAMPLE_RATE, 18'd1000);
      send_frame(1'b0);
      send_frame(1'b0);
      // Buffer shrunk below the current position starts a new buffer.
      write_reg(CSR_BUFFER_SAMPLES, 18'd3);
      send_frame(1'b0);
      send_frame(1'b0);
      // A write to an unmapped index changes nothing.
      write_reg(CSR_UNMAPPED, 18'h2AAAA);
      send_frame(1'b0);
   endtask

   function automatic int unsigned pick_rate();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom_range(1, 64);
         3, 4, 5: begin
            case ($urandom_range(0, 8))
               0: return 8000;
               1: return 11025;
               2: return 16000;
               3: return 22050;
               4: return 32000;
               5: return 44100;
               6: return 48000;
               7: return 96000;
               default: return 192000;
            endcase
         end
         6, 7: return $urandom_range(1, 192000);
         8: return $urandom & 32'h3FFFF;
         default: begin
            case ($urandom_range(0, 2))
               0: return 0;
               1: return 192000;
               default: return 32'h3FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic int unsigned pick_freq();
      case ($urandom_range(0, 9))
         0: return 0;
         1, 2, 3, 4: return $urandom % ((tone_rate == 0) ? 1 : tone_rate);
         5, 6: return $urandom_range(20, 20000);
         7: return $urandom & 32'h3FFFF;
         8: return tone_rate;
         default: return 192000;
      endcase
   endfunction

   function automatic int unsigned pick_frames();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: return $urandom_range(1, 24);
         7: return $urandom_range(25, 300);
         8: return $urandom & 32'h3FFFF;
         default: begin
            case ($urandom_range(0, 3))
               0: return 0;
               1: return 1;
               2: return 4096;
               default: return 4097;
            endcase
         end
      endcase
   endfunction

   // Bursts of random items, each under a freshly drawn setting.
   task automatic test_random();
      int sent;
      int burst;
      int k;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) != 0) write_reg(CSR_SAMPLE_RATE, ACC_W'(pick_rate()));
         if ($urandom_range(0, 2) != 0) write_reg(CSR_FREQUENCY, ACC_W'(pick_freq()));
         if ($urandom_range(0, 1) != 0) write_reg(CSR_BUFFER_SAMPLES, ACC_W'(pick_frames()));
         if ($urandom_range(0, 9) == 0) write_reg(CSR_UNMAPPED, ACC_W'($urandom));
         idle_on = ($urandom_range(0, 3) != 0);
         burst = $urandom_range(8, 60);
         for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            send_frame($urandom_range(0, 15) == 0);
            sent++;
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_quadrants();
      test_open_cases();
      test_random();
      drain();
      repeat (END_WAIT) @(posedge clock);
      if (mismatches == 0 && frames_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
